// ===== design/hlva_pkg.sv =====
// ----------------------------------------------------------------------------
// hlva_pkg: shared types and constants for the Hough line vote accumulator
// Holds the sequencer states, divider handshake structs, register codes and
// the elaboration-time sine table generator.
// ----------------------------------------------------------------------------
package hlva_pkg;

   // Default accumulator geometry
   localparam int ANGLES_DEFAULT    = 256;
   localparam int DISTANCES_DEFAULT = 256;

   // Configuration port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam int REG_SEL_BIT = 2;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [15:0] IMAGE_SIZE_RESET = 16'd256;

   // Request opcodes
   localparam logic OP_VOTE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Fixed-point constants for the sine table
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV_X,
      ST_DIV_Y,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SUM,
      ST_SCALE,
      ST_LOOKUP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   // Taylor term divisors (2k)(2k+1)
   function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
      logic [63:0] r;
      case (k)
         1: r = t / 64'd6;
         2: r = t / 64'd20;
         3: r = t / 64'd42;
         4: r = t / 64'd72;
         5: r = t / 64'd110;
         6: r = t / 64'd156;
         7: r = t / 64'd210;
         default: r = t;
      endcase
      return r;
   endfunction

   // sin(v*pi/2) in Q30 for v in Q30, series through the x^15 term
   function automatic logic signed [63:0] quarter_sine(input logic [63:0] v);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      x    = (v * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int k = 1; k <= 7; k++) begin
         term = taylor_div((term * x2) >> 30, k);
         if (k[0]) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 64'sd0) begin
         acc = 64'sd0;
      end
      if (acc > signed'(Q30_ONE)) begin
         acc = signed'(Q30_ONE);
      end
      return acc;
   endfunction

   // One Q1.15 table entry from the angle as a 32-bit fraction of a turn
   function automatic logic signed [15:0] sine_entry(input logic [63:0] frac);
      logic [1:0]         quad;
      logic [63:0]        u;
      logic [63:0]        v;
      logic signed [63:0] s;
      quad = frac[31:30];
      u    = {34'd0, frac[29:0]};
      v    = quad[0] ? (Q30_ONE - u) : u;
      s    = (quarter_sine(v) + 64'sd16384) >>> 15;
      if (s > 64'sd32767) begin
         s = 64'sd32767;
      end
      return quad[1] ? 16'(-s) : 16'(s);
   endfunction

endpackage

// ===== design/hlva_req_if.sv =====
// ----------------------------------------------------------------------------
// hlva_req_if: request channel
// Valid/ready channel carrying one vote or bin read request.
// ----------------------------------------------------------------------------
interface hlva_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic [7:0]  read_angle;
   logic [7:0]  read_distance;

   modport source (
      output valid, opcode, point_x, point_y, read_angle, read_distance,
      input  ready
   );

   modport sink (
      input  valid, opcode, point_x, point_y, read_angle, read_distance,
      output ready
   );
endinterface

// ===== design/hlva_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hlva_rsp_if: response channel
// Valid/ready channel carrying one bin vote count.
// ----------------------------------------------------------------------------
interface hlva_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] bin_votes;

   modport source (
      output valid, bin_votes,
      input  ready
   );

   modport sink (
      input  valid, bin_votes,
      output ready
   );
endinterface

// ===== design/hlva_divider.sv =====
// ----------------------------------------------------------------------------
// hlva_divider: coordinate normalizer
// Restoring divider, one quotient bit per cycle, giving
// min(floor(dividend * 2^16 / divisor), 65535).
// ----------------------------------------------------------------------------
module hlva_divider
   import hlva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [15:0] quo_ff;
   logic [15:0] den_ff;
   logic        sat_ff;
   logic [15:0] den_in;
   logic [16:0] rem_shift;
   logic        rem_ge;
   logic [16:0] rem_sub;

   // Treat a zero divisor as one
   assign den_in = (div_req.divisor == 16'd0) ? 16'd1 : div_req.divisor;

   // Shift in one bit and trial subtract
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   // Control: busy window and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 4'hF);
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'hF) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: load operands, then iterate
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.dividend;
         quo_ff <= '0;
         den_ff <= den_in;
         sat_ff <= div_req.dividend >= den_in;
      end else if (busy_ff) begin
         rem_ff <= rem_ge ? rem_sub[15:0] : rem_shift[15:0];
         quo_ff <= {quo_ff[14:0], rem_ge};
      end
   end

   // Saturate when the coordinate reaches the image size
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = sat_ff ? 16'hFFFF : quo_ff;

endmodule

// ===== design/hough_line_vote_accumulator.sv =====
// Vote request: two normalizing divisions, then five sequencer steps per angle
//   through the one shared multiplier.
// Read request: read register, then response register; next request once taken.
// Reset: synchronous; a clearing pass then zeroes the 2^(AW+DW) bin memory, one
//   entry per cycle, with requests held off; register writes are taken throughout.
//   image_width and image_height reset to 256.
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator: line Hough transform vote accumulator
// Normalizes a pixel to Q0.16, walks all angle steps forming
// r = xn*cos + yn*sin with a Q1.15 sine table, and increments bin (angle, r).
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator
   import hlva_pkg::*;
#(
   parameter int ANGLES    = ANGLES_DEFAULT,
   parameter int DISTANCES = DISTANCES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   hlva_req_if.sink           req_ch,
   hlva_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int AW        = $clog2(ANGLES);
   localparam int DW        = (DISTANCES > 1) ? $clog2(DISTANCES) : 1;
   localparam int MW        = AW + DW;
   localparam int MEM_DEPTH = 1 << MW;
   localparam int QUARTER   = ANGLES / 4;
   localparam logic signed [50:0] NEG_LIMIT = -51'sd2147483648;

   state_type state_ff;
   state_type state_in;

   logic [15:0]        image_width_ff;
   logic [15:0]        image_height_ff;
   logic [MW-1:0]      clr_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               wr_pend_ff;
   logic [MW-1:0]      wr_addr_ff;
   logic [15:0]        pt_y_ff;
   logic               rd_range_ff;
   logic [15:0]        xn_ff;
   logic [15:0]        yn_ff;
   logic [AW-1:0]      ang_ff;
   logic signed [50:0] mul_ff;
   logic signed [33:0] sum_ff;
   logic [31:0]        rd_ff;

   logic               req_ready;
   logic               req_accept;
   logic               csr_write;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               mem_we;
   logic [MW-1:0]      mem_waddr;
   logic [31:0]        mem_wdata;
   logic [MW-1:0]      mem_raddr;
   logic [MW-1:0]      req_addr;
   logic               req_in_range;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;
   logic [AW:0]        cos_sum;
   logic [AW-1:0]      cos_idx;
   logic signed [15:0] cos_val;
   logic signed [15:0] sin_val;
   logic               ang_last;
   logic [19:0]        lk_hi;
   logic               lk_in_range;
   logic [DW-1:0]      lk_ri;
   logic [MW-1:0]      lk_addr;

   logic signed [15:0] sine_rom [ANGLES];
   logic [31:0]        vote_bins [MEM_DEPTH];

   // Sine table, fixed at elaboration
   for (genvar g = 0; g < ANGLES; g++) begin : g_rom
      localparam logic [63:0] FRAC = (64'(g) << 32) / 64'(ANGLES);
      assign sine_rom[g] = sine_entry(FRAC);
   end

   hlva_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Request handshake
   assign req_ready    = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;

   // Read request address and bounds
   assign req_in_range = (16'(req_ch.read_angle) < 16'(ANGLES)) &&
                         (16'(req_ch.read_distance) < 16'(DISTANCES));
   assign req_addr     = {DW'(req_ch.read_distance), AW'(req_ch.read_angle)};

   // Cosine is the entry a quarter turn ahead
   assign cos_sum  = {1'b0, ang_ff} + (AW+1)'(QUARTER);
   assign cos_idx  = (cos_sum >= (AW+1)'(ANGLES)) ? AW'(cos_sum - (AW+1)'(ANGLES))
                                                  : AW'(cos_sum);
   assign cos_val  = sine_rom[cos_idx];
   assign sin_val  = sine_rom[ang_ff];
   assign ang_last = ang_ff == AW'(ANGLES - 1);

   // Shared multiplier
   assign mul_p = mul_a * mul_b;

   // Bin index: truncate r*DISTANCES toward zero, keep 0..DISTANCES-1
   assign lk_hi       = mul_ff[50:31];
   assign lk_in_range = mul_ff[50] ? (mul_ff > NEG_LIMIT) : (lk_hi < 20'(DISTANCES));
   assign lk_ri       = mul_ff[50] ? '0 : lk_hi[DW-1:0];
   assign lk_addr     = {lk_ri, ang_ff};

   assign mem_raddr = (state_ff == ST_IDLE) ? req_addr : lk_addr;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.opcode)
                  OP_READ: state_in = ST_READ;
                  OP_VOTE: state_in = ST_DIV_X;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_DIV_X: begin
            if (div_rsp.done) state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (div_rsp.done) state_in = ST_MUL_X;
         end
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ang_last ? ST_FLUSH : ST_MUL_X;
         ST_FLUSH:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: divider start, multiplier operands, memory write
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = pt_y_ff;
      div_req.divisor  = image_height_ff;
      mem_we           = 1'b0;
      mem_waddr        = wr_addr_ff;
      mem_wdata        = rd_ff + 32'd1;
      mul_a            = 34'(sin_val);
      mul_b            = signed'({1'b0, yn_ff});
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            div_req.start    = req_accept && (req_ch.opcode == OP_VOTE);
            div_req.dividend = req_ch.point_x;
            div_req.divisor  = image_width_ff;
         end
         ST_DIV_X: begin
            div_req.start = div_rsp.done;
         end
         ST_MUL_X: begin
            mul_a  = 34'(cos_val);
            mul_b  = signed'({1'b0, xn_ff});
            mem_we = wr_pend_ff;
         end
         ST_SCALE: begin
            mul_a = sum_ff;
            mul_b = 17'(DISTANCES);
         end
         ST_FLUSH: begin
            mem_we = wr_pend_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         wr_pend_ff      <= 1'b0;
         image_width_ff  <= IMAGE_SIZE_RESET;
         image_height_ff <= IMAGE_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + MW'(1);
         end
         // Hold the response until taken
         if (state_ff == ST_READ) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Track the pending increment
         if (state_ff == ST_LOOKUP) begin
            wr_pend_ff <= lk_in_range;
         end else if (state_ff == ST_MUL_X || state_ff == ST_FLUSH) begin
            wr_pend_ff <= 1'b0;
         end
         if (csr_write) begin
            if (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH) begin
               image_width_ff <= pwdata[15:0];
            end
            if (paddr[REG_SEL_BIT] == REG_IMAGE_HEIGHT) begin
               image_height_ff <= pwdata[15:0];
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pt_y_ff     <= req_ch.point_y;
         rd_range_ff <= req_in_range;
      end
      case (state_ff)
         ST_READ: begin
            rsp_data_ff <= rd_range_ff ? rd_ff : '0;
         end
         ST_DIV_X: begin
            if (div_rsp.done) xn_ff <= div_rsp.quotient;
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               yn_ff  <= div_rsp.quotient;
               ang_ff <= '0;
            end
         end
         ST_MUL_X: begin
            mul_ff <= mul_p;
         end
         ST_MUL_Y: begin
            mul_ff <= mul_p;
            sum_ff <= $signed(mul_ff[33:0]);
         end
         ST_SUM: begin
            sum_ff <= sum_ff + $signed(mul_ff[33:0]);
         end
         ST_SCALE: begin
            mul_ff <= mul_p;
         end
         ST_LOOKUP: begin
            wr_addr_ff <= lk_addr;
            ang_ff     <= ang_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   // Bin memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vote_bins[mem_waddr] <= mem_wdata;
      end
      rd_ff <= vote_bins[mem_raddr];
   end

   // Response channel
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bin_votes = rsp_data_ff;

   // Register port
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH) ?
                      {16'd0, image_width_ff} : {16'd0, image_height_ff};

endmodule

// ===== dv/tb_hough_line_vote_accumulator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hough_line_vote_accumulator: self-checking bench for the line Hough block
// Drives vote and bin read requests through the valid/ready channels and
// reprograms the image size over the APB port between phases. A scoreboard
// keeps its own sine table and accumulator. It predicts the count returned by
// every bin read and compares it with the response. Idling on both channels
// changes at some of the phase boundaries.
// ----------------------------------------------------------------------------
module tb_hough_line_vote_accumulator;
   import hlva_pkg::*;

   localparam int ANGLE_STEPS    = ANGLES_DEFAULT;
   localparam int DISTANCE_STEPS = DISTANCES_DEFAULT;
   // Covers the longest vote walk
   localparam int VOTE_LATENCY   = 1500;
   // Covers the clearing pass after reset plus one full vote
   localparam int STALL_LIMIT    = 300000;
   localparam int RECENT_POINTS  = 8;

   // -------------------------------------------------------------------------
   // Accumulator scoreboard: sine table, bin counts and pending read results
   // -------------------------------------------------------------------------
   class hough_scoreboard;
      bit signed [15:0] sine_q15 [ANGLE_STEPS];
      bit [31:0]        bin_count [ANGLE_STEPS*DISTANCE_STEPS];
      bit [15:0]        width_reg;
      bit [15:0]        height_reg;
      bit [31:0]        expected_votes [$];
      int               error_count;

      function new();
         bit [63:0] frac;
         bit [63:0] u;
         bit [63:0] v;
         longint signed s;
         for (int i = 0; i < ANGLE_STEPS; i++) begin
            frac = (64'(i) << 32) / 64'(ANGLE_STEPS);
            u    = {34'd0, frac[29:0]};
            v    = frac[30] ? (64'd1073741824 - u) : u;
            s    = (sine_q30(v) + 64'sd16384) >>> 15;
            if (s > 64'sd32767) begin
               s = 64'sd32767;
            end
            sine_q15[i] = frac[31] ? 16'(-s) : 16'(s);
         end
         width_reg   = 16'd256;
         height_reg  = 16'd256;
         error_count = 0;
      endfunction

      // sin(v*pi/2) in Q30 by a truncated Taylor series, v in 0..2^30
      function longint signed sine_q30(bit [63:0] v);
         bit [63:0]     ang;
         bit [63:0]     ang_sq;
         bit [63:0]     term;
         longint signed sum;
         ang    = (v * 64'd1686629713) >> 30;
         ang_sq = (ang * ang) >> 30;
         term   = ang;
         sum    = $signed(ang);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
         end
         return sum;
      endfunction

      // Scale a coordinate to a Q0.16 fraction of the image size
      function bit [15:0] normalize(bit [15:0] coord, bit [15:0] size);
         bit [63:0] quot;
         quot = {32'd0, coord, 16'd0} / ((size == 16'd0) ? 64'd1 : 64'(size));
         return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
      endfunction

      // Distance index that a point lands in at one angle step, may be out of range
      function int bin_distance(bit [15:0] x, bit [15:0] y, int angle);
         longint signed xn;
         longint signed yn;
         longint signed cos_q;
         longint signed sin_q;
         longint signed r;
         longint signed scaled;
         xn     = normalize(x, width_reg);
         yn     = normalize(y, height_reg);
         cos_q  = sine_q15[(angle + ANGLE_STEPS / 4) % ANGLE_STEPS];
         sin_q  = sine_q15[angle];
         r      = xn * cos_q + yn * sin_q;
         scaled = r * DISTANCE_STEPS;
         if (scaled >= 0) begin
            return int'(scaled >>> 31);
         end
         return -int'((-scaled) >>> 31);
      endfunction

      function void set_register(logic reg_sel, bit [31:0] data);
         if (reg_sel == REG_IMAGE_WIDTH) begin
            width_reg = data[15:0];
         end else begin
            height_reg = data[15:0];
         end
      endfunction

      // Apply one accepted request: cast its votes or queue the bin it reads
      function void note_request(logic opcode, bit [15:0] x, bit [15:0] y,
                                 bit [7:0] angle, bit [7:0] distance);
         int dist_idx;
         if (opcode == OP_READ) begin
            if (int'(angle) < ANGLE_STEPS && int'(distance) < DISTANCE_STEPS) begin
               expected_votes.push_back(bin_count[int'(distance)*ANGLE_STEPS + int'(angle)]);
            end else begin
               expected_votes.push_back(32'd0);
            end
         end else begin
            for (int a = 0; a < ANGLE_STEPS; a++) begin
               dist_idx = bin_distance(x, y, a);
               if (dist_idx >= 0 && dist_idx < DISTANCE_STEPS) begin
                  bin_count[dist_idx*ANGLE_STEPS + a] =
                     bin_count[dist_idx*ANGLE_STEPS + a] + 32'd1;
               end
            end
         end
      endfunction

      // Compare one response with the oldest pending bin read
      function void check_result(bit [31:0] votes);
         bit [31:0] want;
         if (expected_votes.size() == 0) begin
            $error("unexpected response: bin_votes actual %0d", votes);
            error_count++;
         end else begin
            want = expected_votes.pop_front();
            if (votes !== want) begin
               $error("bin_votes mismatch: expected %0d, actual %0d", want, votes);
               error_count++;
            end
         end
      endfunction

      function int pending();
         return expected_votes.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, buses
   // -------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   hlva_req_if req_bus ();
   hlva_rsp_if rsp_bus ();

   hough_scoreboard sb = new();

   int        send_idle_pct;
   int        recv_idle_pct;
   int        quiet_cycles = 0;
   bit [15:0] recent_x [$];
   bit [15:0] recent_y [$];

   always #1 clock = ~clock;

   hough_line_vote_accumulator dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus.sink),
      .rsp_ch  (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Track both handshakes and watch for a hang
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.opcode, req_bus.point_x, req_bus.point_y,
                            req_bus.read_angle, req_bus.read_distance);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.bin_votes);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_hough_line_vote_accumulator: done, errors");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Present one request, hold it until taken, return at the next falling edge
   task automatic send_request(logic opcode, bit [15:0] x, bit [15:0] y,
                               bit [7:0] angle, bit [7:0] distance);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= opcode;
      req_bus.point_x       <= x;
      req_bus.point_y       <= y;
      req_bus.read_angle    <= angle;
      req_bus.read_distance <= distance;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic cast_vote(bit [15:0] x, bit [15:0] y);
      send_request(OP_VOTE, x, y, 8'($urandom), 8'($urandom));
      recent_x.push_back(x);
      recent_y.push_back(y);
      if (recent_x.size() > RECENT_POINTS) begin
         void'(recent_x.pop_front());
         void'(recent_y.pop_front());
      end
   endtask

   // Read the bin that a point votes into at one angle, or a random one if none
   task automatic read_voted_bin(bit [15:0] x, bit [15:0] y, bit [7:0] angle);
      int dist_idx;
      dist_idx = sb.bin_distance(x, y, int'(angle));
      if (dist_idx < 0 || dist_idx >= DISTANCE_STEPS) begin
         dist_idx = $urandom_range(0, DISTANCE_STEPS - 1);
      end
      send_request(OP_READ, 16'($urandom), 16'($urandom), angle, 8'(dist_idx));
   endtask

   // APB write: setup then access, return at a falling edge with the bus idle
   task automatic write_register(logic reg_sel, bit [15:0] value);
      bit [31:0] data;
      data    = {16'($urandom), value};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({reg_sel, 2'b00});
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      sb.set_register(reg_sel, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, let every read return and the last vote walk finish
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) begin
         @(posedge clock);
      end
      repeat (VOTE_LATENCY) @(posedge clock);
      @(negedge clock);
   endtask

   // Extremes, saturation, zero and small negative distances
   task automatic run_directed();
      send_request(OP_READ, 16'h0000, 16'h0000, 8'd0, 8'd0);
      send_request(OP_READ, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
      // Origin votes distance zero at every angle
      cast_vote(16'd0, 16'd0);
      send_request(OP_READ, 16'h1234, 16'h5678, 8'd0, 8'd0);
      send_request(OP_READ, 16'h0000, 16'h0000, 8'd255, 8'd0);
      // Tiny x: negative r truncates to bin zero
      cast_vote(16'd1, 16'd0);
      send_request(OP_READ, 16'h0000, 16'h0000, 8'd128, 8'd0);
      send_request(OP_READ, 16'h0000, 16'h0000, 8'd64, 8'd0);
      // Coordinates at or past the image size saturate
      cast_vote(16'hFFFF, 16'hFFFF);
      read_voted_bin(16'hFFFF, 16'hFFFF, 8'd0);
      read_voted_bin(16'hFFFF, 16'hFFFF, 8'd32);
      read_voted_bin(16'hFFFF, 16'hFFFF, 8'd255);
      cast_vote(16'd256, 16'd300);
      read_voted_bin(16'd256, 16'd300, 8'd16);
      // Far point: large negative r casts no vote around half a turn
      cast_vote(16'd255, 16'd0);
      read_voted_bin(16'd255, 16'd0, 8'd128);
      send_request(OP_READ, 16'h0000, 16'h0000, 8'd128, 8'd0);
      cast_vote(16'd128, 16'd128);
      read_voted_bin(16'd128, 16'd128, 8'd0);
      read_voted_bin(16'd128, 16'd128, 8'd64);
      read_voted_bin(16'd128, 16'd128, 8'd200);
   endtask

   // Votes on points mostly inside the image, reads mostly aimed at bins they hit
   task automatic run_random(int count);
      int        pick;
      int        span_x;
      int        span_y;
      bit [15:0] x;
      bit [15:0] y;
      span_x = (sb.width_reg == 16'd0) ? 1 : int'(sb.width_reg);
      span_y = (sb.height_reg == 16'd0) ? 1 : int'(sb.height_reg);
      recent_x.delete();
      recent_y.delete();
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 38) begin
            if (recent_x.size() > 0 && $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, recent_x.size() - 1);
               x    = recent_x[pick];
               y    = recent_y[pick];
            end else if ($urandom_range(0, 4) == 0) begin
               x = 16'($urandom);
               y = 16'($urandom);
            end else begin
               x = 16'($urandom_range(0, span_x - 1));
               y = 16'($urandom_range(0, span_y - 1));
            end
            cast_vote(x, y);
         end else if (recent_x.size() > 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, recent_x.size() - 1);
            read_voted_bin(recent_x[pick], recent_y[pick], 8'($urandom));
         end else begin
            send_request(OP_READ, 16'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= OP_VOTE;
      req_bus.point_x       <= 16'd0;
      req_bus.point_y       <= 16'd0;
      req_bus.read_angle    <= 8'd0;
      req_bus.read_distance <= 8'd0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      send_idle_pct         = 34;
      recv_idle_pct         = 81;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      // Ordinary image size
      wait_quiet();
      write_register(REG_IMAGE_WIDTH, 16'd640);
      write_register(REG_IMAGE_HEIGHT, 16'd480);
      run_random(150);

      // Extremes, the other idling mix
      wait_quiet();
      send_idle_pct = 81;
      recv_idle_pct = 34;
      write_register(REG_IMAGE_WIDTH, 16'd1);
      write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
      run_random(150);

      // Zero divisor acts as one
      wait_quiet();
      write_register(REG_IMAGE_WIDTH, 16'hFFFF);
      write_register(REG_IMAGE_HEIGHT, 16'd0);
      run_random(150);

      // Back to back, no idling
      wait_quiet();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_IMAGE_WIDTH, 16'd0);
      write_register(REG_IMAGE_HEIGHT, 16'd200);
      run_random(150);

      wait_quiet();
      if (sb.pending() != 0) begin
         $error("bin_votes: %0d expected results never arrived", sb.pending());
      end
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("tb_hough_line_vote_accumulator: done, clean");
      end else begin
         $display("tb_hough_line_vote_accumulator: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/hlva_pkg.sv
design/hlva_req_if.sv
design/hlva_rsp_if.sv
design/hlva_divider.sv
design/hough_line_vote_accumulator.sv
dv/tb_hough_line_vote_accumulator.sv
